### rtl/core/tsp_pkg.sv
package tsp_pkg;

   localparam int SLOTS_DEF      = 64;
   localparam int RING_DEPTH_DEF = 32;
   localparam logic [31:0] RISE  = 32'd22;

   typedef enum logic [2:0] {
      CMD_ALLOC  = 3'd0,
      CMD_EXTEND = 3'd1,
      CMD_FREE   = 3'd2,
      CMD_LIFE   = 3'd3,
      CMD_TICK   = 3'd4,
      CMD_QUERY  = 3'd5,
      CMD_READ   = 3'd6,
      CMD_NONE   = 3'd7
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ALLOC,
      ST_EXT_RD,
      ST_EXT_WR,
      ST_QUERY,
      ST_READ_WAIT,
      ST_READ_DONE,
      ST_TICK_SLOT,
      ST_TICK_CHK,
      ST_TICK_RD,
      ST_TICK_WR,
      ST_TICK_NEXT,
      ST_RESP
   } state_type;

endpackage

### rtl/core/tsp_req_if.sv
interface tsp_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         cmd;
   logic [6:0]         slot;
   logic               convect;
   logic [7:0]         segments;
   logic [30:0]        life;
   logic [7:0]         slide_speed;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic [4:0]         point_index;

   modport source (output valid, cmd, slot, convect, segments, life, slide_speed,
                   pos_x, pos_y, pos_z, point_index, input ready);
   modport sink   (input valid, cmd, slot, convect, segments, life, slide_speed,
                   pos_x, pos_y, pos_z, point_index, output ready);
endinterface

### rtl/core/tsp_rsp_if.sv
interface tsp_rsp_if;
   logic               valid;
   logic               ready;
   logic [6:0]         handle;
   logic [5:0]         length;
   logic [15:0]        scroll;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;

   modport source (output valid, handle, length, scroll, out_x, out_y, out_z,
                   input ready);
   modport sink   (input valid, handle, length, scroll, out_x, out_y, out_z,
                   output ready);
endinterface

### rtl/core/tsp_csr_if.sv
interface tsp_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### rtl/core/trail_slot_pool.sv
// Command flow: alloc probes slots from the search pointer on, wrapping, until one is free or
// all were probed; tick walks every slot and raises the points of each used convecting slot.
// Throughput: one command at a time, req ready again the cycle after the rsp transfer; one
// sequencer, one slot record read port and one point memory port set that limit.
// Reset: synchronous, active high; clears used and convect flags, search pointer and paused.
// Slot records (loaded on alloc) and point memory are not cleared.
module trail_slot_pool
   import tsp_pkg::*;
#(
   parameter int SLOTS      = SLOTS_DEF,
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   tsp_req_if.sink   req,
   tsp_rsp_if.source rsp,
   tsp_csr_if.sink   csr
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int RW = $clog2(RING_DEPTH + 1);
   localparam int AW = SW + PW;
   localparam int MEM = SLOTS * (1 << PW);

   state_type state_ff, state_in;

   logic              paused_ff;
   logic [SLOTS-1:0]  used_ff;
   logic [SLOTS-1:0]  conv_ff;
   logic [RW-1:0]     size_ff  [SLOTS];
   logic [30:0]       life_ff  [SLOTS];
   logic [15:0]       scroll_ff[SLOTS];
   logic [7:0]        rate_ff  [SLOTS];
   logic [PW-1:0]     head_ff  [SLOTS];
   logic [PW-1:0]     tail_ff  [SLOTS];
   logic [SW-1:0]     search_ff;

   logic [31:0] mem_x[MEM];
   logic [31:0] mem_y[MEM];
   logic [31:0] mem_z[MEM];

   cmd_type       cmd_ff;
   logic [6:0]    hnd_ff;
   logic          conv_in_ff;
   logic [7:0]    seg_ff;
   logic [30:0]   lifev_ff;
   logic [7:0]    spd_ff;
   logic [31:0]   px_ff, py_ff, pz_ff;
   logic [4:0]    pidx_ff;

   logic [SW-1:0] cur_ff, cur_in;
   logic [SW:0]   cnt_ff, cnt_in;
   logic [RW-1:0] pt_ff, pt_in;

   logic [6:0]    o_handle_ff;
   logic [5:0]    o_length_ff;
   logic [15:0]   o_scroll_ff;
   logic [31:0]   o_x_ff, o_y_ff, o_z_ff;

   logic [31:0]   rd_x_ff, rd_y_ff, rd_z_ff;

   logic [RW-1:0] rd_size_ff;
   logic [30:0]   rd_life_ff;
   logic [15:0]   rd_scroll_ff;
   logic [7:0]    rd_rate_ff;
   logic [PW-1:0] rd_head_ff, rd_tail_ff;

   logic          hvalid;
   logic [SW-1:0] sidx;
   assign hvalid = (hnd_ff != 7'd0) && ({25'd0, hnd_ff} <= 32'(SLOTS));
   assign sidx   = SW'(hnd_ff - 7'd1);

   // slot record read address: walk pointer during tick, addressed slot otherwise
   logic          tick_st;
   logic [SW-1:0] ra;
   assign tick_st = (state_ff == ST_TICK_SLOT) || (state_ff == ST_TICK_CHK) ||
                    (state_ff == ST_TICK_RD) || (state_ff == ST_TICK_WR) ||
                    (state_ff == ST_TICK_NEXT);
   assign ra = tick_st ? cur_ff : sidx;

   logic [RW-1:0] size_eff;
   assign size_eff = (rd_size_ff == '0) ? RW'(1) : rd_size_ff;

   logic [RW-1:0] seg_clamp;
   always_comb begin
      if ({24'd0, seg_ff} > 32'(RING_DEPTH)) seg_clamp = RW'(RING_DEPTH);
      else if (seg_ff == 8'd0)              seg_clamp = RW'(1);
      else                                  seg_clamp = RW'(seg_ff);
   end

   logic [RW:0] len_sum;
   logic [RW:0] len_mod;
   always_comb begin
      len_sum = {1'b0, RW'(rd_head_ff)} + {1'b0, size_eff} - {1'b0, RW'(rd_tail_ff)};
      len_mod = (len_sum >= {1'b0, size_eff}) ? len_sum - {1'b0, size_eff} : len_sum;
   end

   logic [RW-1:0] head_nx, tail_nx;
   always_comb begin
      head_nx = RW'(rd_head_ff) + RW'(1);
      if (head_nx >= size_eff) head_nx = '0;
      tail_nx = RW'(rd_tail_ff) + RW'(1);
      if (tail_nx >= size_eff) tail_nx = '0;
   end

   logic [AW-1:0] ext_addr, rp_addr, tk_addr;
   assign ext_addr = {sidx, rd_head_ff};
   assign rp_addr  = {sidx, PW'(pidx_ff)};
   assign tk_addr  = {cur_ff, PW'(pt_ff)};

   logic rp_ok;
   assign rp_ok = hvalid && ({27'd0, pidx_ff} < 32'(RING_DEPTH));

   logic [RW-1:0] tk_lim;
   assign tk_lim = rd_size_ff;

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = (state_ff == ST_RESP);
   assign rsp.handle = o_handle_ff;
   assign rsp.length = o_length_ff;
   assign rsp.scroll = o_scroll_ff;
   assign rsp.out_x  = o_x_ff;
   assign rsp.out_y  = o_y_ff;
   assign rsp.out_z  = o_z_ff;

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      cnt_in   = cnt_ff;
      pt_in    = pt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (cmd_ff)
               CMD_ALLOC: begin
                  state_in = ST_ALLOC;
                  cur_in   = search_ff;
                  cnt_in   = '0;
               end
               CMD_EXTEND: state_in = ST_EXT_RD;
               CMD_QUERY:  state_in = ST_QUERY;
               CMD_READ:   state_in = ST_READ_WAIT;
               CMD_TICK: begin
                  state_in = ST_TICK_SLOT;
                  cur_in   = '0;
                  cnt_in   = '0;
               end
               default:    state_in = ST_RESP;
            endcase
         end
         ST_ALLOC: begin
            if (!used_ff[cur_ff] || cnt_ff == (SW+1)'(SLOTS - 1)) state_in = ST_RESP;
            else begin
               cnt_in = cnt_ff + 1'b1;
               cur_in = (cur_ff == SW'(SLOTS - 1)) ? '0 : cur_ff + 1'b1;
            end
         end
         ST_EXT_RD:  state_in = ST_EXT_WR;
         ST_EXT_WR:  state_in = ST_RESP;
         ST_QUERY:   state_in = ST_RESP;
         ST_READ_WAIT: state_in = ST_READ_DONE;
         ST_READ_DONE: state_in = ST_RESP;
         ST_TICK_SLOT: begin
            pt_in    = '0;
            state_in = ST_TICK_CHK;
         end
         ST_TICK_CHK: begin
            if (used_ff[cur_ff] && conv_ff[cur_ff] && tk_lim != '0) state_in = ST_TICK_RD;
            else state_in = ST_TICK_NEXT;
         end
         ST_TICK_RD: state_in = ST_TICK_WR;
         ST_TICK_WR: begin
            if (pt_ff + RW'(1) >= tk_lim) state_in = ST_TICK_NEXT;
            else begin
               pt_in    = pt_ff + RW'(1);
               state_in = ST_TICK_RD;
            end
         end
         ST_TICK_NEXT: begin
            if (cnt_ff == (SW+1)'(SLOTS - 1)) state_in = ST_RESP;
            else begin
               cnt_in   = cnt_ff + 1'b1;
               cur_in   = cur_ff + 1'b1;
               state_in = ST_TICK_SLOT;
            end
         end
         ST_RESP: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cur_ff <= cur_in;
      cnt_ff <= cnt_in;
      pt_ff  <= pt_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req.valid) begin
         cmd_ff     <= cmd_type'(req.cmd);
         hnd_ff     <= req.slot;
         conv_in_ff <= req.convect;
         seg_ff     <= req.segments;
         lifev_ff   <= req.life;
         spd_ff     <= req.slide_speed;
         px_ff      <= req.pos_x;
         py_ff      <= req.pos_y;
         pz_ff      <= req.pos_z;
         pidx_ff    <= req.point_index;
      end
   end

   always_ff @(posedge clock) begin
      rd_size_ff   <= size_ff[ra];
      rd_life_ff   <= life_ff[ra];
      rd_scroll_ff <= scroll_ff[ra];
      rd_rate_ff   <= rate_ff[ra];
      rd_head_ff   <= head_ff[ra];
      rd_tail_ff   <= tail_ff[ra];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EXT_WR && hvalid && used_ff[sidx] && !paused_ff) begin
         mem_x[ext_addr] <= px_ff;
         mem_y[ext_addr] <= py_ff;
         mem_z[ext_addr] <= pz_ff;
      end else if (state_ff == ST_TICK_WR) begin
         mem_y[tk_addr] <= rd_y_ff + RISE;
      end
      if (state_ff == ST_TICK_RD) begin
         rd_y_ff <= mem_y[tk_addr];
      end else begin
         rd_x_ff <= mem_x[rp_addr];
         rd_y_ff <= mem_y[rp_addr];
         rd_z_ff <= mem_z[rp_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DISPATCH) begin
         o_handle_ff <= '0;
         o_length_ff <= '0;
         o_scroll_ff <= '0;
         o_x_ff      <= '0;
         o_y_ff      <= '0;
         o_z_ff      <= '0;
      end
      if (state_ff == ST_ALLOC && !used_ff[cur_ff]) o_handle_ff <= 7'(cur_ff) + 7'd1;
      if (state_ff == ST_QUERY && hvalid && used_ff[sidx]) begin
         o_length_ff <= 6'(len_mod) + 6'd1;
         o_scroll_ff <= rd_scroll_ff;
      end
      if (state_ff == ST_READ_DONE && rp_ok) begin
         o_x_ff <= rd_x_ff;
         o_y_ff <= rd_y_ff;
         o_z_ff <= rd_z_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         paused_ff <= 1'b0;
         used_ff   <= '0;
         conv_ff   <= '0;
         search_ff <= '0;
      end else begin
         if (csr.valid) paused_ff <= csr.data;
         case (state_ff)
            ST_ALLOC: begin
               if (!used_ff[cur_ff]) begin
                  used_ff[cur_ff]   <= 1'b1;
                  conv_ff[cur_ff]   <= conv_in_ff;
                  size_ff[cur_ff]   <= seg_clamp;
                  life_ff[cur_ff]   <= lifev_ff;
                  scroll_ff[cur_ff] <= '0;
                  rate_ff[cur_ff]   <= spd_ff;
                  head_ff[cur_ff]   <= '0;
                  tail_ff[cur_ff]   <= '0;
                  search_ff <= (cur_ff == SW'(SLOTS - 1)) ? '0 : cur_ff + 1'b1;
               end
            end
            ST_EXT_WR: begin
               if (hvalid && used_ff[sidx] && !paused_ff) begin
                  head_ff[sidx] <= PW'(head_nx);
                  if (head_nx == RW'(rd_tail_ff)) tail_ff[sidx] <= PW'(tail_nx);
               end
            end
            ST_DISPATCH: begin
               if (cmd_ff == CMD_FREE && hvalid) begin
                  used_ff[sidx] <= 1'b0;
                  conv_ff[sidx] <= 1'b0;
                  head_ff[sidx] <= '0;
                  tail_ff[sidx] <= '0;
               end
               if (cmd_ff == CMD_LIFE && hvalid && used_ff[sidx]) life_ff[sidx] <= lifev_ff;
            end
            ST_TICK_NEXT: begin
               if (used_ff[cur_ff]) begin
                  scroll_ff[cur_ff] <= rd_scroll_ff + 16'(rd_rate_ff);
                  if (rd_life_ff <= 31'd1) begin
                     life_ff[cur_ff] <= '0;
                     used_ff[cur_ff] <= 1'b0;
                     conv_ff[cur_ff] <= 1'b0;
                     head_ff[cur_ff] <= '0;
                     tail_ff[cur_ff] <= '0;
                  end else begin
                     life_ff[cur_ff] <= rd_life_ff - 31'd1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid) else $error("ready while response pending");
   a_accept_leaves: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> state_ff == ST_DISPATCH) else $error("accept lost");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.handle)) else $error("rsp drop");
   a_handle_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> {25'd0, rsp.handle} <= 32'(SLOTS)) else $error("bad handle");

endmodule
